/* hw/rtl/u8n1_pkg.sv */
// Shared types and constants for the 8N1 UART transmit/receive block.
// No dependencies; imported by every module of the block.
`default_nettype none

package u8n1_pkg;

   localparam int DATA_BITS  = 8;   // data bits per frame
   localparam int BYTE_W     = 8;   // width of the byte fields
   localparam int BIT_SEL_W  = $clog2(BYTE_W);
   localparam int IDX_W      = 4;   // bit index counters
   localparam int TICK_W     = 16;  // bit period and timers
   localparam int DATA_W     = 16;  // tdata width on both channels

   localparam logic [IDX_W-1:0]  LAST_DATA_IDX  = IDX_W'(DATA_BITS);
   localparam logic [IDX_W-1:0]  STOP_IDX       = IDX_W'(DATA_BITS + 1);
   localparam logic [IDX_W-1:0]  BYTE_IDX       = IDX_W'(BYTE_W);
   localparam logic [TICK_W-1:0] BIT_TICKS_RESET = TICK_W'(104);

   // transmitter status for one tick
   typedef struct packed {
      logic level;
      logic busy;
      logic dropped;
   } tx_out_type;

   // receiver status for one tick
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
      logic              line_low;
   } rx_out_type;

endpackage

`default_nettype wire

/* hw/rtl/u8n1_tx.sv */
// 8N1 transmitter: start bit, data bits LSB first, stop bit, timer based.
// Depends on u8n1_pkg.
`default_nettype none

module u8n1_tx
   import u8n1_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,          // one tick is processed
   input  wire logic [TICK_W-1:0] period,        // bit period, never 0
   input  wire logic              send_request,
   input  wire logic [BYTE_W-1:0] send_byte,
   output tx_out_type             result
);

   logic              tx_active_ff, tx_active_in;
   logic [BYTE_W-1:0] tx_shift_ff, tx_shift_in;
   logic [IDX_W-1:0]  tx_idx_ff, tx_idx_in;
   logic [TICK_W-1:0] tx_timer_ff, tx_timer_in;

   always_comb begin
      logic              act;
      logic [BYTE_W-1:0] shift;
      logic [IDX_W-1:0]  idx;
      logic [IDX_W-1:0]  dpos;
      logic [TICK_W-1:0] timer;
      act    = tx_active_ff;
      shift  = tx_shift_ff;
      idx    = tx_idx_ff;
      timer  = tx_timer_ff;
      dpos   = idx - IDX_W'(1);
      result = '0;
      result.level = 1'b1;
      if (send_request) begin
         if (act) begin
            result.dropped = 1'b1;
         end else begin
            act   = 1'b1;
            shift = send_byte;
            idx   = '0;
            timer = period;
         end
      end
      if (act) begin
         result.busy = 1'b1;
         dpos = idx - IDX_W'(1);
         if (idx == '0) begin
            result.level = 1'b0;
         end else if (idx <= LAST_DATA_IDX) begin
            // bits beyond the byte go out as zero
            result.level = (dpos < BYTE_IDX) ? shift[dpos[BIT_SEL_W-1:0]] : 1'b0;
         end else begin
            result.level = 1'b1;
         end
         if (timer <= TICK_W'(1)) begin
            idx   = idx + IDX_W'(1);
            timer = period;
            if (idx > STOP_IDX) begin
               act = 1'b0;
               idx = '0;
            end
         end else begin
            timer = timer - TICK_W'(1);
         end
      end
      tx_active_in = step ? act   : tx_active_ff;
      tx_shift_in  = step ? shift : tx_shift_ff;
      tx_idx_in    = step ? idx   : tx_idx_ff;
      tx_timer_in  = step ? timer : tx_timer_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_active_ff <= 1'b0;
         tx_shift_ff  <= '0;
         tx_idx_ff    <= '0;
         tx_timer_ff  <= '0;
      end else begin
         tx_active_ff <= tx_active_in;
         tx_shift_ff  <= tx_shift_in;
         tx_idx_ff    <= tx_idx_in;
         tx_timer_ff  <= tx_timer_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/u8n1_rx.sv */
// 8N1 receiver: start detect, half-bit wait, one sample per bit period.
// Depends on u8n1_pkg.
`default_nettype none

module u8n1_rx
   import u8n1_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,          // one tick is processed
   input  wire logic [TICK_W-1:0] period,        // bit period, never 0
   input  wire logic              rx_level,
   output rx_out_type             result
);

   typedef enum logic [1:0] {
      RX_HUNT,
      RX_HALF,
      RX_SAMPLE,
      RX_LAST
   } rx_phase_type;

   rx_phase_type      rx_phase_ff, rx_phase_in;
   logic [BYTE_W-1:0] rx_shift_ff, rx_shift_in;
   logic [IDX_W-1:0]  rx_idx_ff, rx_idx_in;
   logic [TICK_W-1:0] rx_timer_ff, rx_timer_in;

   always_comb begin
      rx_phase_type      phase;
      logic [BYTE_W-1:0] shift;
      logic [IDX_W-1:0]  idx;
      logic [TICK_W-1:0] timer;
      logic [TICK_W-1:0] half;
      phase  = rx_phase_ff;
      shift  = rx_shift_ff;
      idx    = rx_idx_ff;
      timer  = rx_timer_ff;
      half   = period >> 1;
      result = '0;
      result.line_low = ~rx_level;
      unique case (rx_phase_ff)
         RX_HUNT: begin
            if (!rx_level) begin
               shift = '0;
               idx   = '0;
               if (half == '0) begin
                  phase = RX_SAMPLE;
                  timer = period;
               end else begin
                  phase = RX_HALF;
                  timer = half;
               end
            end
         end
         RX_HALF: begin
            if (timer <= TICK_W'(1)) begin
               phase = RX_SAMPLE;
               timer = period;
            end else begin
               timer = timer - TICK_W'(1);
            end
         end
         RX_SAMPLE: begin
            if (timer <= TICK_W'(1)) begin
               // a ninth bit has no place in the byte
               if (rx_level && (idx < BYTE_IDX)) begin
                  shift[idx[BIT_SEL_W-1:0]] = 1'b1;
               end
               idx   = idx + IDX_W'(1);
               timer = period;
               if (idx >= LAST_DATA_IDX) begin
                  phase = RX_LAST;
               end
            end else begin
               timer = timer - TICK_W'(1);
            end
         end
         RX_LAST: begin
            if (timer <= TICK_W'(1)) begin
               result.valid = 1'b1;
               result.data  = shift;
               phase = RX_HUNT;
               timer = '0;
               idx   = '0;
            end else begin
               timer = timer - TICK_W'(1);
            end
         end
         default: begin
            phase = RX_HUNT;
         end
      endcase
      rx_phase_in = step ? phase : rx_phase_ff;
      rx_shift_in = step ? shift : rx_shift_ff;
      rx_idx_in   = step ? idx   : rx_idx_ff;
      rx_timer_in = step ? timer : rx_timer_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_phase_ff <= RX_HUNT;
         rx_shift_ff <= '0;
         rx_idx_ff   <= '0;
         rx_timer_ff <= '0;
      end else begin
         rx_phase_ff <= rx_phase_in;
         rx_shift_ff <= rx_shift_in;
         rx_idx_ff   <= rx_idx_in;
         rx_timer_ff <= rx_timer_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/uart_8n1_transmit_receive_top.sv */
// Top level of the 8N1 UART: input register, transmitter and receiver, result register.
// Depends on u8n1_pkg, u8n1_tx and u8n1_rx.
`default_nettype none

// Each req transfer is one tick of the line timebase: the sampled receive
// level plus an optional byte to send. Each tick yields exactly one rsp
// transfer with the transmit level, busy/dropped flags and receiver status.
// The block takes one tick per clock cycle unless rsp_tready stalls it; a tick
// passes an input register, transmitter/receiver logic and a result register,
// and its result is held on rsp_tdata until it is taken at an edge where
// rsp_tready is high. An empty result stage still takes the input stage item
// while the result side stalls; req_tready drops once both stages hold an item
// and rsp_tready is low. In steady back-to-back flow both stages are full, so a
// stall on rsp_tready drops req_tready in the same cycle (combinational path
// from rsp_tready to req_tready). The transmitter accepts a byte only when idle
// (a request while busy is flagged as dropped); it sends a low start bit,
// 8 data bits LSB first and a high stop bit, bit_ticks ticks each.
// The receiver hunts for a low level, waits half a bit, samples 8 bits one
// bit period apart and reports the byte one bit period after the last sample,
// without checking the stop bit. The user must write bit_ticks (reset 104, 0
// acts as 1) via csr_wr_en/csr_wr_data only while no tick is in flight; unchecked.

module uart_8n1_transmit_receive_top
   import u8n1_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // tick input
   input  wire logic              req_tvalid,
   output      logic              req_tready,
   input  wire logic [DATA_W-1:0] req_tdata,  // [0] rx_level, [1] send_request,
                                              // [9:2] send_byte, [15:10] zero
   // tick result
   output      logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   output      logic [DATA_W-1:0] rsp_tdata,  // [0] tx_level, [1] tx_busy,
                                              // [2] send_dropped, [3] received_valid,
                                              // [11:4] received_byte, [12] line_low,
                                              // [15:13] zero
   // configuration
   input  wire logic              csr_wr_en,
   input  wire logic [TICK_W-1:0] csr_wr_data // bit_ticks
);

   logic [TICK_W-1:0] bit_ticks_ff, bit_ticks_in;
   logic [TICK_W-1:0] period;

   // input stage
   logic              in_valid_ff, in_valid_in;
   logic              in_rx_ff;
   logic              in_req_ff;
   logic [BYTE_W-1:0] in_byte_ff;

   // result stage
   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] out_data_ff, out_data_in;

   logic       advance;   // input stage item moves into the result stage
   logic       load;      // req transfer
   tx_out_type tx_res;
   rx_out_type rx_res;

   assign bit_ticks_in = csr_wr_en ? csr_wr_data : bit_ticks_ff;
   assign period       = (bit_ticks_ff == '0) ? TICK_W'(1) : bit_ticks_ff;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign load       = req_tvalid && req_tready;

   assign in_valid_in  = load ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   u8n1_tx u_tx (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .period       (period),
      .send_request (in_req_ff),
      .send_byte    (in_byte_ff),
      .result       (tx_res)
   );

   u8n1_rx u_rx (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .period   (period),
      .rx_level (in_rx_ff),
      .result   (rx_res)
   );

   assign out_data_in = advance ?
      {3'b000, rx_res.line_low, rx_res.data, rx_res.valid,
       tx_res.dropped, tx_res.busy, tx_res.level} : out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ticks_ff <= BIT_TICKS_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         bit_ticks_ff <= bit_ticks_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (load) begin
         in_rx_ff   <= req_tdata[0];
         in_req_ff  <= req_tdata[1];
         in_byte_ff <= req_tdata[9:2];
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // an item held in the input stage is never lost while the result side stalls
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_req_ff))
      else $error("input stage item lost while stalled");

   // an idle transmitter leaves the line high
   a_idle_high: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> rsp_tdata[0])
      else $error("tx line low while idle");

   // a request is dropped only while a frame is on the line
   a_drop_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[1])
      else $error("request dropped while transmitter idle");

   // received byte reads zero unless a byte completes
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[3] |-> rsp_tdata[11:4] == '0)
      else $error("received byte nonzero without valid");

endmodule

`default_nettype wire
